/* src/scpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the servo command pulse controller.
// No dependencies; used by every module of the block.

package scpc_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'd255;
    localparam logic [7:0] CODE_ANGLES    = 8'd101;
    localparam logic [7:0] CODE_MOTOR_DIR = 8'd200;
    localparam logic [7:0] CODE_DUTY      = 8'd201;
    localparam logic [7:0] CODE_SENSOR    = 8'd202;

    localparam logic [7:0] MOTOR_ONE = 8'd1;
    localparam logic [7:0] MOTOR_TWO = 8'd2;
    localparam logic [7:0] DIR_MAX   = 8'd2;

    localparam logic [1:0] REG_PULSE_BASE = 2'd0;
    localparam logic [1:0] REG_STEP       = 2'd1;
    localparam logic [1:0] REG_SLOT       = 2'd2;

    localparam logic [11:0] PULSE_BASE_RESET = 12'd500;
    localparam logic [4:0]  STEP_RESET       = 5'd13;
    localparam logic [15:0] SLOT_RESET       = 16'd2700;

    localparam int SERVO_IDX_W = 2;
    localparam int PIN_W       = 3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_ANGLES,
        OP_MOTOR1,
        OP_MOTOR2,
        OP_DUTY,
        OP_SENSOR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] arg0;
        logic [7:0] arg1;
        logic [7:0] arg2;
    } t_item;

    typedef struct packed {
        logic [11:0] pulse_base_us;
        logic [4:0]  step_us_per_degree;
        logic [15:0] slot_length_us;
    } t_cfg;

endpackage

/* src/scpc_front.sv */
`timescale 1ns / 1ps
// Front end: gathers received bytes into packets and classifies each request.
// Depends on scpc_pkg.

module scpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_cmd,
    input  logic [7:0]           i_rx_byte,
    output scpc_pkg::t_item      o_item
);

    logic [1:0] r_byte_count;
    logic [7:0] r_pkt [3];

    always_comb begin
        o_item.op   = scpc_pkg::OP_NONE;
        o_item.arg0 = r_pkt[1];
        o_item.arg1 = r_pkt[2];
        o_item.arg2 = i_rx_byte;
        if (i_cmd) begin
            o_item.op = scpc_pkg::OP_TICK;
        end else if (i_rx_byte != scpc_pkg::SYNC_BYTE && r_byte_count == 2'd3) begin
            if (r_pkt[0] == scpc_pkg::CODE_ANGLES) begin
                o_item.op = scpc_pkg::OP_ANGLES;
            end else if (r_pkt[0] == scpc_pkg::CODE_MOTOR_DIR) begin
                if (r_pkt[2] <= scpc_pkg::DIR_MAX) begin
                    if (r_pkt[1] == scpc_pkg::MOTOR_ONE) begin
                        o_item.op = scpc_pkg::OP_MOTOR1;
                    end else if (r_pkt[1] == scpc_pkg::MOTOR_TWO) begin
                        o_item.op = scpc_pkg::OP_MOTOR2;
                    end
                end
            end else if (r_pkt[0] == scpc_pkg::CODE_DUTY) begin
                o_item.op = scpc_pkg::OP_DUTY;
            end else if (r_pkt[0] == scpc_pkg::CODE_SENSOR) begin
                o_item.op = scpc_pkg::OP_SENSOR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 2'd0;
        end else if (i_accept && !i_cmd && i_rx_byte != scpc_pkg::SYNC_BYTE) begin
            if (r_byte_count == 2'd3) begin
                r_byte_count <= 2'd0;
            end else begin
                r_byte_count <= r_byte_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_cmd && i_rx_byte != scpc_pkg::SYNC_BYTE
                && r_byte_count != 2'd3) begin
            r_pkt[r_byte_count] <= i_rx_byte;
        end
    end

endmodule

/* src/scpc_queue.sv */
`timescale 1ns / 1ps
// Two-entry request queue between the front end and the back end.
// Depends on scpc_pkg.

module scpc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  scpc_pkg::t_item      i_item,
    input  logic                 i_pop,
    output scpc_pkg::t_item      o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    scpc_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* src/scpc_back.sv */
`timescale 1ns / 1ps
// Back end: carries out requests, runs the servo slot scheduler and holds
// the output register. Depends on scpc_pkg.

module scpc_back #(
    parameter int SERVO_COUNT = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scpc_pkg::t_cfg                   i_cfg,
    input  scpc_pkg::t_item                  i_head,
    input  logic                             i_empty,
    output logic                             o_pop,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [scpc_pkg::PIN_W-1:0]       o_servo_pins,
    output logic [1:0]                       o_motor_one_pins,
    output logic [1:0]                       o_motor_two_pins,
    output logic [7:0]                       o_pwm_duty,
    output logic                             o_sensor_read_strobe
);

    localparam int IW = scpc_pkg::SERVO_IDX_W;

    logic [15:0]   r_pulse_width [SERVO_COUNT];
    logic [IW-1:0] r_servo_index;
    logic [15:0]   r_slot_timer;
    logic [3:0]    r_motor;
    logic [7:0]    r_duty;
    logic          r_valid;
    logic [scpc_pkg::PIN_W-1:0] r_servo_pins;
    logic          r_strobe;

    logic [15:0]   n_pulse_width [SERVO_COUNT];
    logic [IW-1:0] n_servo_index;
    logic [15:0]   n_slot_timer;
    logic [3:0]    n_motor;
    logic [7:0]    n_duty;
    logic [scpc_pkg::PIN_W-1:0] n_servo_pins;
    logic          n_strobe;

    logic [16:0]   timer_inc;
    logic [IW:0]   index_inc;
    logic [7:0]    angle [3];
    logic [12:0]   product [3];

    assign o_pop = !i_empty && (!r_valid || !i_stall);

    assign angle[0] = i_head.arg0;
    assign angle[1] = i_head.arg1;
    assign angle[2] = i_head.arg2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            product[k] = {8'd0, i_cfg.step_us_per_degree} * {5'd0, angle[k]};
        end
    end

    always_comb begin
        timer_inc = {1'b0, r_slot_timer} + 17'd1;
        index_inc = {1'b0, r_servo_index} + {{IW{1'b0}}, 1'b1};

        n_pulse_width = r_pulse_width;
        n_servo_index = r_servo_index;
        n_slot_timer  = r_slot_timer;
        n_motor       = r_motor;
        n_duty        = r_duty;
        n_strobe      = 1'b0;

        case (i_head.op)
            scpc_pkg::OP_TICK: begin
                if (timer_inc >= {1'b0, i_cfg.slot_length_us}) begin
                    n_slot_timer = 16'd0;
                    if (index_inc >= (IW+1)'(SERVO_COUNT)) begin
                        n_servo_index = '0;
                    end else begin
                        n_servo_index = index_inc[IW-1:0];
                    end
                end else begin
                    n_slot_timer = timer_inc[15:0];
                end
            end
            scpc_pkg::OP_ANGLES: begin
                for (int k = 0; k < SERVO_COUNT; k++) begin
                    n_pulse_width[k] = {4'd0, i_cfg.pulse_base_us} + {3'd0, product[k]};
                end
            end
            scpc_pkg::OP_MOTOR1: begin
                n_motor[1:0] = i_head.arg1[1:0];
            end
            scpc_pkg::OP_MOTOR2: begin
                n_motor[3:2] = i_head.arg1[1:0];
            end
            scpc_pkg::OP_DUTY: begin
                n_duty = i_head.arg0;
            end
            scpc_pkg::OP_SENSOR: begin
                n_strobe = 1'b1;
            end
            default: begin
            end
        endcase

        n_servo_pins = '0;
        for (int k = 0; k < SERVO_COUNT; k++) begin
            n_servo_pins[k] = (n_servo_index == IW'(k))
                              && (n_slot_timer < n_pulse_width[k])
                              && (n_slot_timer < i_cfg.slot_length_us);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SERVO_COUNT; k++) begin
                r_pulse_width[k] <= 16'd0;
            end
            r_servo_index <= '0;
            r_slot_timer  <= 16'd0;
            r_motor       <= 4'd0;
            r_duty        <= 8'd0;
            r_valid       <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pulse_width <= n_pulse_width;
                r_servo_index <= n_servo_index;
                r_slot_timer  <= n_slot_timer;
                r_motor       <= n_motor;
                r_duty        <= n_duty;
                r_valid       <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_servo_pins <= n_servo_pins;
            r_strobe     <= n_strobe;
        end
    end

    assign o_valid              = r_valid;
    assign o_servo_pins         = r_servo_pins;
    assign o_motor_one_pins     = r_motor[1:0];
    assign o_motor_two_pins     = r_motor[3:2];
    assign o_pwm_duty           = r_duty;
    assign o_sensor_read_strobe = r_strobe;

endmodule

/* src/servo_command_pulse_controller_top.sv */
`timescale 1ns / 1ps
// Top level of the servo command pulse controller: configuration registers
// and the front end, queue and back end. Depends on scpc_pkg and its modules.

// The block takes one request per clock cycle while the queue is not full,
// either a received byte or a one microsecond tick, and returns exactly one
// result per request, showing the servo, motor and duty outputs after that
// request. The front end writes the classified request into a two-entry
// queue, and the back end reads one request a cycle, unless the output is
// stalled, into its output register. With no stall at the output the
// sustained rate is one request per cycle; the queue absorbs short stalls.

module servo_command_pulse_controller_top #(
    parameter int SERVO_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_servo_pins,
    output logic [1:0]  o_motor_one_pins,
    output logic [1:0]  o_motor_two_pins,
    output logic [7:0]  o_pwm_duty,
    output logic        o_sensor_read_strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    scpc_pkg::t_cfg  r_cfg;
    scpc_pkg::t_item front_item;
    scpc_pkg::t_item queue_head;
    logic            in_accept;
    logic            queue_empty;
    logic            queue_full;
    logic            back_pop;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign o_stall   = queue_full;
    assign in_accept = i_valid && !queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_base_us      <= scpc_pkg::PULSE_BASE_RESET;
            r_cfg.step_us_per_degree <= scpc_pkg::STEP_RESET;
            r_cfg.slot_length_us     <= scpc_pkg::SLOT_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                scpc_pkg::REG_PULSE_BASE: r_cfg.pulse_base_us      <= pwdata[11:0];
                scpc_pkg::REG_STEP:       r_cfg.step_us_per_degree <= pwdata[4:0];
                scpc_pkg::REG_SLOT:       r_cfg.slot_length_us     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            scpc_pkg::REG_PULSE_BASE: prdata = {20'd0, r_cfg.pulse_base_us};
            scpc_pkg::REG_STEP:       prdata = {27'd0, r_cfg.step_us_per_degree};
            scpc_pkg::REG_SLOT:       prdata = {16'd0, r_cfg.slot_length_us};
            default:                  prdata = 32'd0;
        endcase
    end

    scpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .o_item    (front_item)
    );

    scpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_head  (queue_head),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    scpc_back #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_head               (queue_head),
        .i_empty              (queue_empty),
        .o_pop                (back_pop),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_servo_pins         (o_servo_pins),
        .o_motor_one_pins     (o_motor_one_pins),
        .o_motor_two_pins     (o_motor_two_pins),
        .o_pwm_duty           (o_pwm_duty),
        .o_sensor_read_strobe (o_sensor_read_strobe)
    );

endmodule

/* dv/tb_servo_command_pulse_controller_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for servo_command_pulse_controller_top: drives bytes and ticks,
// programs the registers over APB and compares every result with a pin-level model.
// Depends on scpc_pkg and the RTL of the block only.

module tb_servo_command_pulse_controller_top;

    localparam int SERVOS = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 200;
    localparam logic [7:0] DIR_STOP = 8'd0;
    localparam logic [7:0] DIR_FORWARD = 8'd1;
    localparam logic [7:0] UNKNOWN_CODE = 8'd17;

    typedef struct packed {
        logic [2:0] servo;
        logic [1:0] motor_one;
        logic [1:0] motor_two;
        logic [7:0] duty;
        logic       strobe;
    } t_pin_levels;

    class t_pin_level_model;
        bit [11:0] base_us;
        bit [4:0]  step_us;
        bit [15:0] slot_us;
        bit [7:0]  packet [3];
        bit [1:0]  bytes_held;
        bit [15:0] width_us [3];
        bit [1:0]  servo_sel;
        bit [15:0] slot_elapsed;
        bit [3:0]  motor_pins;
        bit [7:0]  duty;
        t_pin_levels pending [$];
        int errors;

        function new();
            base_us = scpc_pkg::PULSE_BASE_RESET;
            step_us = scpc_pkg::STEP_RESET;
            slot_us = scpc_pkg::SLOT_RESET;
            errors = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                scpc_pkg::REG_PULSE_BASE: base_us = value[11:0];
                scpc_pkg::REG_STEP: step_us = value[4:0];
                scpc_pkg::REG_SLOT: slot_us = value[15:0];
                default: ;
            endcase
        endfunction

        function bit run_packet(bit [7:0] last);
            bit [7:0] angle [3];
            bit sensor;
            sensor = 1'b0;
            angle[0] = packet[1];
            angle[1] = packet[2];
            angle[2] = last;
            case (packet[0])
                scpc_pkg::CODE_ANGLES: begin
                    for (int n = 0; n < SERVOS; n++) begin
                        width_us[n] = base_us + step_us * angle[n];
                    end
                end
                scpc_pkg::CODE_MOTOR_DIR: begin
                    if (packet[2] <= scpc_pkg::DIR_MAX) begin
                        if (packet[1] == scpc_pkg::MOTOR_ONE) begin
                            motor_pins[1:0] = packet[2][1:0];
                        end else if (packet[1] == scpc_pkg::MOTOR_TWO) begin
                            motor_pins[3:2] = packet[2][1:0];
                        end
                    end
                end
                scpc_pkg::CODE_DUTY: duty = packet[1];
                scpc_pkg::CODE_SENSOR: sensor = 1'b1;
                default: ;
            endcase
            return sensor;
        endfunction

        function void take_request(bit cmd, bit [7:0] rx);
            t_pin_levels levels;
            bit [16:0] next_elapsed;
            levels = '0;
            if (!cmd) begin
                if (rx != scpc_pkg::SYNC_BYTE) begin
                    if (bytes_held == 2'd3) begin
                        levels.strobe = run_packet(rx);
                        bytes_held = 2'd0;
                    end else begin
                        packet[bytes_held] = rx;
                        bytes_held = bytes_held + 2'd1;
                    end
                end
            end else begin
                next_elapsed = slot_elapsed + 17'd1;
                if (next_elapsed >= slot_us) begin
                    slot_elapsed = 16'd0;
                    if (int'(servo_sel) + 1 >= SERVOS) begin
                        servo_sel = 2'd0;
                    end else begin
                        servo_sel = servo_sel + 2'd1;
                    end
                end else begin
                    slot_elapsed = next_elapsed[15:0];
                end
            end
            if (int'(servo_sel) < SERVOS && slot_elapsed < width_us[servo_sel]
                    && slot_elapsed < slot_us) begin
                levels.servo[servo_sel] = 1'b1;
            end
            levels.motor_one = motor_pins[1:0];
            levels.motor_two = motor_pins[3:2];
            levels.duty = duty;
            pending.push_back(levels);
        endfunction

        function void flag(string what);
            if (errors < 10) begin
                $display("mismatch: %s", what);
            end
            errors++;
        endfunction

        function void compare_output(t_pin_levels got);
            t_pin_levels want;
            if (pending.size() == 0) begin
                flag("result arrived with no request outstanding");
            end else begin
                want = pending.pop_front();
                if (got.servo !== want.servo) begin
                    flag($sformatf("servo_pins expected %0h got %0h", want.servo, got.servo));
                end
                if (got.motor_one !== want.motor_one) begin
                    flag($sformatf("motor_one_pins expected %0h got %0h",
                        want.motor_one, got.motor_one));
                end
                if (got.motor_two !== want.motor_two) begin
                    flag($sformatf("motor_two_pins expected %0h got %0h",
                        want.motor_two, got.motor_two));
                end
                if (got.duty !== want.duty) begin
                    flag($sformatf("pwm_duty expected %0d got %0d", want.duty, got.duty));
                end
                if (got.strobe !== want.strobe) begin
                    flag($sformatf("sensor_read_strobe expected %0b got %0b",
                        want.strobe, got.strobe));
                end
            end
        endfunction

        function int count();
            return pending.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_servo_pins;
    logic [1:0]  o_motor_one_pins;
    logic [1:0]  o_motor_two_pins;
    logic [7:0]  o_pwm_duty;
    logic        o_sensor_read_strobe;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_pin_level_model levels = new();
    int requests_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    servo_command_pulse_controller_top #(
        .SERVO_COUNT(SERVOS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_servo_pins(o_servo_pins),
        .o_motor_one_pins(o_motor_one_pins),
        .o_motor_two_pins(o_motor_two_pins),
        .o_pwm_duty(o_pwm_duty),
        .o_sensor_read_strobe(o_sensor_read_strobe),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            levels.compare_output({o_servo_pins, o_motor_one_pins, o_motor_two_pins,
                o_pwm_duty, o_sensor_read_strobe});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_request(input logic cmd, input logic [7:0] rx);
        if (requests_sent < 550) begin
            gap_pct = 33;
            stall_pct = 88;
        end else if (requests_sent < 1100) begin
            gap_pct = 88;
            stall_pct = 33;
        end else begin
            gap_pct = 0;
            stall_pct = 0;
        end
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        levels.take_request(cmd, rx);
        if (cmd || rx != scpc_pkg::SYNC_BYTE) begin
            requests_sent++;
        end
    endtask

    task automatic push_packet(input logic [7:0] code, input logic [7:0] b1,
            input logic [7:0] b2, input logic [7:0] b3, input bit noisy);
        logic [7:0] bytes [4];
        bytes = '{code, b1, b2, b3};
        for (int n = 0; n < 4; n++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                push_request(1'b0, scpc_pkg::SYNC_BYTE);
            end
            push_request(1'b0, bytes[n]);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (levels.count() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        levels.set_register(idx, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            levels.flag($sformatf("register %0d read %0h after writing %0h", idx, prdata, value));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int base, input int step, input int slot);
        wait_for_results();
        write_setting(scpc_pkg::REG_PULSE_BASE, base);
        write_setting(scpc_pkg::REG_STEP, step);
        write_setting(scpc_pkg::REG_SLOT, slot);
    endtask

    task automatic random_packet();
        logic [7:0] code;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b1 = 8'($urandom_range(0, 254));
        b2 = 8'($urandom_range(0, 254));
        b3 = 8'($urandom_range(0, 254));
        case ($urandom_range(0, 4))
            0: code = scpc_pkg::CODE_ANGLES;
            1: begin
                code = scpc_pkg::CODE_MOTOR_DIR;
                case ($urandom_range(0, 3))
                    0: b1 = scpc_pkg::MOTOR_ONE;
                    1: b1 = scpc_pkg::MOTOR_TWO;
                    default: ;
                endcase
                case ($urandom_range(0, 4))
                    0: b2 = DIR_STOP;
                    1: b2 = DIR_FORWARD;
                    2: b2 = scpc_pkg::DIR_MAX;
                    3: b2 = scpc_pkg::DIR_MAX + 8'd1;
                    default: ;
                endcase
            end
            2: code = scpc_pkg::CODE_DUTY;
            3: code = scpc_pkg::CODE_SENSOR;
            default: code = 8'($urandom_range(0, 254));
        endcase
        push_packet(code, b1, b2, b3, 1'b1);
    endtask

    task automatic run_traffic(input int count);
        int stop_at;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    repeat ($urandom_range(1, 8)) begin
                        push_request(1'b1, 8'($urandom_range(0, 255)));
                    end
                end
                5, 6, 7, 8: random_packet();
                default: push_request(1'b0, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_request(1'b0, scpc_pkg::SYNC_BYTE);
        push_packet(scpc_pkg::CODE_ANGLES, 8'd0, 8'd128, 8'd254, 1'b0);
        push_packet(scpc_pkg::CODE_MOTOR_DIR, scpc_pkg::MOTOR_ONE, DIR_FORWARD, 8'd0, 1'b0);
        push_packet(scpc_pkg::CODE_MOTOR_DIR, scpc_pkg::MOTOR_TWO, scpc_pkg::DIR_MAX, 8'd0,
            1'b0);
        push_packet(scpc_pkg::CODE_MOTOR_DIR, 8'd0, DIR_FORWARD, 8'd0, 1'b0);
        push_packet(scpc_pkg::CODE_MOTOR_DIR, scpc_pkg::MOTOR_ONE, scpc_pkg::DIR_MAX + 8'd1,
            8'd0, 1'b0);
        push_packet(scpc_pkg::CODE_DUTY, 8'd254, 8'd0, 8'd0, 1'b0);
        push_packet(scpc_pkg::CODE_SENSOR, 8'd0, 8'd0, 8'd0, 1'b0);
        push_packet(UNKNOWN_CODE, 8'd1, 8'd2, 8'd3, 1'b0);
        push_request(1'b1, 8'd0);
        push_request(1'b1, 8'd255);

        apply_settings(2, 1, 4);
        run_traffic(PHASE_ITEMS);
        apply_settings(0, 0, 1);
        run_traffic(PHASE_ITEMS);
        apply_settings(4095, 31, 65535);
        run_traffic(PHASE_ITEMS);
        apply_settings(5, 0, 0);
        run_traffic(PHASE_ITEMS);
        apply_settings(0, 1, 200);
        run_traffic(PHASE_ITEMS / 2);
        wait_for_results();
        run_traffic(PHASE_ITEMS / 2);
        apply_settings(10, 2, 37);
        run_traffic(PHASE_ITEMS);
        repeat (2) begin
            apply_settings($urandom_range(0, 60), $urandom_range(0, 3), $urandom_range(1, 90));
            run_traffic(PHASE_ITEMS);
        end
        wait_for_results();

        if (levels.errors == 0 && levels.count() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/scpc_pkg.sv
src/scpc_front.sv
src/scpc_queue.sv
src/scpc_back.sv
src/servo_command_pulse_controller_top.sv
dv/tb_servo_command_pulse_controller_top.sv
